/* rtl/atis_pkg.sv */
// ----------------------------------------------------------------------------
// atis_pkg
// shared types and constants of the ata taskfile issue sequencer
// ----------------------------------------------------------------------------
package atis_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;

    // register file indexes
    localparam logic [2:0] CFG_DEVICE_PRESENT  = 3'd0;
    localparam logic [2:0] CFG_DEVICE_IS_ATA   = 3'd1;
    localparam logic [2:0] CFG_LBA28_SUPPORTED = 3'd2;
    localparam logic [2:0] CFG_TOTAL_SECTORS   = 3'd3;
    localparam logic [2:0] CFG_DRIVE_SELECT    = 3'd4;

    localparam logic [31:0] LBA48_LIMIT = 32'h1000_0000;

    // register blocks and offsets
    localparam logic       BLK_COMMAND  = 1'b0;
    localparam logic       BLK_CONTROL  = 1'b1;
    localparam logic [2:0] OFF_NONE     = 3'd0;
    localparam logic [2:0] OFF_DEV_CTRL = 3'd2;
    localparam logic [2:0] OFF_COUNT    = 3'd2;
    localparam logic [2:0] OFF_LBA_LO   = 3'd3;
    localparam logic [2:0] OFF_LBA_MID  = 3'd4;
    localparam logic [2:0] OFF_LBA_HI   = 3'd5;
    localparam logic [2:0] OFF_DEVICE   = 3'd6;
    localparam logic [2:0] OFF_COMMAND  = 3'd7;

    localparam logic [7:0] CTRL_NIEN     = 8'h02;
    localparam logic [7:0] CTRL_HOB      = 8'h80;
    localparam logic [7:0] DEV_CHS       = 8'hA0;
    localparam logic [7:0] DEV_LBA       = 8'hE0;
    localparam logic [7:0] CMD_READ      = 8'h20;
    localparam logic [7:0] CMD_READ_EXT  = 8'h24;
    localparam logic [7:0] CMD_WRITE     = 8'h30;
    localparam logic [7:0] CMD_WRITE_EXT = 8'h34;

    // emit steps: lba48 runs all, chs and lba28 jump from the device write to the tail
    localparam logic [4:0] STEP_FIRST  = 5'd0;
    localparam logic [4:0] STEP_DEVICE = 5'd1;
    localparam logic [4:0] STEP_TAIL   = 5'd14;
    localparam logic [4:0] STEP_LAST   = 5'd18;

    typedef enum logic [1:0] {
        MODE_CHS   = 2'd0,
        MODE_LBA28 = 2'd1,
        MODE_LBA48 = 2'd2
    } t_mode;

    typedef struct packed {
        logic        device_present;
        logic        device_is_ata;
        logic        lba28_supported;
        logic [31:0] total_sectors;
        logic        drive_select;
    } t_cfg;

    typedef struct packed {
        logic       rejected;
        t_mode      mode;
        logic [7:0] dev;
        logic [7:0] cmd;
        logic [7:0] cnt;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
    } t_desc;

    typedef struct packed {
        logic  valid;
        t_desc desc;
    } t_q_head;

endpackage

/* rtl/ata_taskfile_issue_sequencer_top.sv */
// ----------------------------------------------------------------------------
// ata_taskfile_issue_sequencer_top
// sector request to ata taskfile register write sequence
// ----------------------------------------------------------------------------
// path: a request passes intake stages a, b and c, the queue and the emitter output register
// throughput: one word per cycle while tready allows, 7 words per request (19 for lba48, 1 if rejected)
// the emitter, giving one register write per cycle unless the output stalls, sets the request rate
// reset: synchronous active low, empties pipeline and queue, clears config to zero
module ata_taskfile_issue_sequencer_top #(
    parameter int unsigned QUEUE_DEPTH = atis_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // direction, lba[31:0], sector_count[7:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // port_block, port_offset[2:0], write_value[7:0]
    output logic        m_axis_tuser,   // rejected
    output logic        m_axis_tlast
);
    import atis_pkg::*;

    t_cfg    r_cfg;
    t_desc   front_desc;
    t_q_head q_head;
    logic    front_push;
    logic    q_full;
    logic    back_pop;
    logic    out_blk;
    logic [2:0] out_off;
    logic [7:0] out_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_DEVICE_PRESENT:  r_cfg.device_present  <= i_cfg_wdata[0];
                CFG_DEVICE_IS_ATA:   r_cfg.device_is_ata   <= i_cfg_wdata[0];
                CFG_LBA28_SUPPORTED: r_cfg.lba28_supported <= i_cfg_wdata[0];
                CFG_TOTAL_SECTORS:   r_cfg.total_sectors   <= i_cfg_wdata;
                CFG_DRIVE_SELECT:    r_cfg.drive_select    <= i_cfg_wdata[0];
                default:             r_cfg <= r_cfg;
            endcase
        end
    end

    atis_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_direction    (s_axis_tdata[0]),
        .i_lba          (s_axis_tdata[32:1]),
        .i_sector_count (s_axis_tdata[40:33]),
        .i_q_full       (q_full),
        .o_push         (front_push),
        .o_desc         (front_desc)
    );

    atis_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_desc  (front_desc),
        .o_full  (q_full),
        .i_pop   (back_pop),
        .o_head  (q_head)
    );

    atis_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (q_head),
        .o_pop         (back_pop),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_port_block  (out_blk),
        .o_port_offset (out_off),
        .o_write_value (out_val),
        .o_rejected    (m_axis_tuser),
        .o_last_write  (m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, out_val, out_off, out_blk};

`ifndef SYNTH
    a_reject_single_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata[11:0] == 12'd0))
        else $error("rejected word not a lone final word");

    a_last_is_opcode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast && !m_axis_tuser) |->
        (m_axis_tdata[3:1] == OFF_COMMAND && m_axis_tdata[0] == BLK_COMMAND))
        else $error("final word is not the command register write");

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");
`endif

endmodule

/* rtl/atis_front.sv */
// ----------------------------------------------------------------------------
// atis_front
// request intake: range check, mode choice and chs address split
// ----------------------------------------------------------------------------
module atis_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  atis_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic            i_direction,
    input  logic [31:0]     i_lba,
    input  logic [7:0]      i_sector_count,
    input  logic            i_q_full,
    output logic            o_push,
    output atis_pkg::t_desc o_desc
);
    import atis_pkg::*;

    localparam int unsigned RECIP_SHIFT = 38;
    localparam logic [28:0] DIV1008_RECIP = 29'((64'd1 << RECIP_SHIFT) / 64'd1008);
    localparam logic [10:0] CHS_CYL_SPAN  = 11'd1008;
    localparam logic [10:0] DIV63_RECIP   = 11'd1041;

    // stage a: registered request
    logic        r_a_valid;
    logic        r_a_dir;
    logic [31:0] r_a_lba;
    logic [7:0]  r_a_cnt;
    // stage b
    logic        r_b_valid;
    logic        r_b_dir;
    logic [31:0] r_b_lba;
    logic [7:0]  r_b_cnt;
    logic        r_b_rej;
    t_mode       r_b_mode;
    logic [18:0] r_b_q0;
    // stage c
    logic        r_c_valid;
    logic        r_c_dir;
    logic [31:0] r_c_lba;
    logic [7:0]  r_c_cnt;
    logic        r_c_rej;
    t_mode       r_c_mode;
    logic [15:0] r_c_cyl;
    logic [9:0]  r_c_rem;

    logic        a_ready;
    logic        b_ready;
    logic        c_ready;
    logic        a_rej;
    t_mode       a_mode;
    logic [56:0] a_prod;
    logic [28:0] b_qx;
    logic [28:0] b_r0;
    logic [18:0] b_q;
    logic [9:0]  b_r;
    logic [20:0] c_hprod;
    logic [3:0]  c_head;
    logic [9:0]  c_h63;
    logic [7:0]  c_sector;
    logic [3:0]  dev_head;

    assign c_ready = !r_c_valid || !i_q_full;
    assign b_ready = !r_b_valid || c_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_ready = a_ready;

    always_comb begin
        a_rej = !i_cfg.device_present || !i_cfg.device_is_ata ||
                (({1'b0, r_a_lba} + {25'd0, r_a_cnt}) > {1'b0, i_cfg.total_sectors});
        if (r_a_lba >= LBA48_LIMIT) begin
            a_mode = MODE_LBA48;
        end else if (i_cfg.lba28_supported) begin
            a_mode = MODE_LBA28;
        end else begin
            a_mode = MODE_CHS;
        end
        a_prod = {29'd0, r_a_lba[27:0]} * {28'd0, DIV1008_RECIP};
    end

    always_comb begin
        b_qx = ({10'd0, r_b_q0} << 10) - ({10'd0, r_b_q0} << 4);
        b_r0 = {1'b0, r_b_lba[27:0]} - b_qx;
        if (b_r0[10:0] >= CHS_CYL_SPAN) begin
            b_q = r_b_q0 + 19'd1;
            b_r = 10'(b_r0[10:0] - CHS_CYL_SPAN);
        end else begin
            b_q = r_b_q0;
            b_r = b_r0[9:0];
        end
    end

    always_comb begin
        c_hprod  = {11'd0, r_c_rem} * {10'd0, DIV63_RECIP};
        c_head   = c_hprod[19:16];
        c_h63    = ({6'd0, c_head} << 6) - {6'd0, c_head};
        c_sector = 8'(r_c_rem - c_h63) + 8'd1;
        o_desc.rejected = r_c_rej;
        o_desc.mode     = r_c_mode;
        o_desc.cnt      = r_c_cnt;
        o_desc.b3       = 8'd0;
        dev_head        = 4'd0;
        case (r_c_mode)
            MODE_LBA48: begin
                o_desc.b0 = r_c_lba[7:0];
                o_desc.b1 = r_c_lba[15:8];
                o_desc.b2 = r_c_lba[23:16];
                o_desc.b3 = r_c_lba[31:24];
            end
            MODE_LBA28: begin
                o_desc.b0 = r_c_lba[7:0];
                o_desc.b1 = r_c_lba[15:8];
                o_desc.b2 = r_c_lba[23:16];
                dev_head  = r_c_lba[27:24];
            end
            default: begin
                o_desc.b0 = c_sector;
                o_desc.b1 = r_c_cyl[7:0];
                o_desc.b2 = r_c_cyl[15:8];
                dev_head  = c_head;
            end
        endcase
        o_desc.dev = ((r_c_mode == MODE_CHS) ? DEV_CHS : DEV_LBA) |
                     {3'd0, i_cfg.drive_select, dev_head};
        if (!r_c_dir) begin
            o_desc.cmd = (r_c_mode == MODE_LBA48) ? CMD_READ_EXT : CMD_READ;
        end else begin
            o_desc.cmd = (r_c_mode == MODE_LBA48) ? CMD_WRITE_EXT : CMD_WRITE;
        end
    end

    assign o_push = r_c_valid && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_valid <= i_valid;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
            if (c_ready) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && i_valid) begin
            r_a_dir <= i_direction;
            r_a_lba <= i_lba;
            r_a_cnt <= i_sector_count;
        end
        if (b_ready && r_a_valid) begin
            r_b_dir  <= r_a_dir;
            r_b_lba  <= r_a_lba;
            r_b_cnt  <= r_a_cnt;
            r_b_rej  <= a_rej;
            r_b_mode <= a_mode;
            r_b_q0   <= a_prod[56:38];
        end
        if (c_ready && r_b_valid) begin
            r_c_dir  <= r_b_dir;
            r_c_lba  <= r_b_lba;
            r_c_cnt  <= r_b_cnt;
            r_c_rej  <= r_b_rej;
            r_c_mode <= r_b_mode;
            r_c_cyl  <= b_q[15:0];
            r_c_rem  <= b_r;
        end
    end

endmodule

/* rtl/atis_queue.sv */
// ----------------------------------------------------------------------------
// atis_queue
// short descriptor queue between intake and emitter
// ----------------------------------------------------------------------------
module atis_queue #(
    parameter int unsigned DEPTH = atis_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  atis_pkg::t_desc   i_desc,
    output logic              o_full,
    input  logic              i_pop,
    output atis_pkg::t_q_head o_head
);
    import atis_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_desc         r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_pop;

    assign o_full      = (r_count == CNT_FULL);
    assign o_head.valid = (r_count != '0);
    assign o_head.desc  = r_mem[r_rd_ptr];
    assign do_pop       = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PW'(1);
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* rtl/atis_back.sv */
// ----------------------------------------------------------------------------
// atis_back
// register write emitter, one word per cycle from the queue head while the output is ready
// ----------------------------------------------------------------------------
module atis_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  atis_pkg::t_q_head i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_port_block,
    output logic [2:0]        o_port_offset,
    output logic [7:0]        o_write_value,
    output logic              o_rejected,
    output logic              o_last_write
);
    import atis_pkg::*;

    logic [4:0] r_step;
    logic       r_valid;
    logic       r_blk;
    logic [2:0] r_off;
    logic [7:0] r_val;
    logic       r_rej;
    logic       r_last;

    logic       advance;
    logic       fire;
    logic       w_blk;
    logic [2:0] w_off;
    logic [7:0] w_val;
    logic       w_last;
    logic [4:0] n_step;
    t_desc      d;

    assign d       = i_head.desc;
    assign advance = !r_valid || i_ready;
    assign fire    = advance && i_head.valid;
    assign o_pop   = fire && w_last;

    always_comb begin
        w_blk  = BLK_COMMAND;
        w_off  = OFF_NONE;
        w_val  = 8'd0;
        w_last = 1'b0;
        if (d.rejected) begin
            w_last = 1'b1;
        end else begin
            case (r_step)
                5'd0, 5'd4, 5'd7, 5'd10, 5'd13: begin
                    w_blk = BLK_CONTROL;
                    w_off = OFF_DEV_CTRL;
                    w_val = CTRL_NIEN;
                end
                5'd2, 5'd5, 5'd8, 5'd11: begin
                    w_blk = BLK_CONTROL;
                    w_off = OFF_DEV_CTRL;
                    w_val = CTRL_HOB | CTRL_NIEN;
                end
                5'd1: begin
                    w_off = OFF_DEVICE;
                    w_val = d.dev;
                end
                5'd3: w_off = OFF_COUNT;
                5'd6: begin
                    w_off = OFF_LBA_LO;
                    w_val = d.b3;
                end
                5'd9:  w_off = OFF_LBA_MID;
                5'd12: w_off = OFF_LBA_HI;
                5'd14: begin
                    w_off = OFF_COUNT;
                    w_val = d.cnt;
                end
                5'd15: begin
                    w_off = OFF_LBA_LO;
                    w_val = d.b0;
                end
                5'd16: begin
                    w_off = OFF_LBA_MID;
                    w_val = d.b1;
                end
                5'd17: begin
                    w_off = OFF_LBA_HI;
                    w_val = d.b2;
                end
                default: begin
                    w_off  = OFF_COMMAND;
                    w_val  = d.cmd;
                    w_last = 1'b1;
                end
            endcase
        end
        if (w_last) begin
            n_step = STEP_FIRST;
        end else if (r_step == STEP_DEVICE && d.mode != MODE_LBA48) begin
            n_step = STEP_TAIL;
        end else begin
            n_step = r_step + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= STEP_FIRST;
        end else begin
            if (advance) begin
                r_valid <= i_head.valid;
            end
            if (fire) begin
                r_step <= n_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_blk  <= w_blk;
            r_off  <= w_off;
            r_val  <= w_val;
            r_rej  <= d.rejected;
            r_last <= w_last;
        end
    end

    assign o_valid       = r_valid;
    assign o_port_block  = r_blk;
    assign o_port_offset = r_off;
    assign o_write_value = r_val;
    assign o_rejected    = r_rej;
    assign o_last_write  = r_last;

endmodule
